### hw/rtl/lse_pkg.sv
package lse_pkg;

    localparam int unsigned CHUNK_W   = 3;
    localparam int unsigned LEN_W     = 23;
    localparam int unsigned PCOUNT_W  = 25;
    localparam int unsigned HDR_IDX_W = 3;

    localparam logic [PCOUNT_W-1:0] PIXEL_LIMIT = 25'd16777216;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_LEN_OK  = 2'd0,
        KIND_LEN_BAD = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] length_value;
        logic             last;
    } res_t;

    typedef struct packed {
        logic             fit_ok;
        logic [LEN_W-1:0] max_len;
    } lim_t;

endpackage

### hw/rtl/lse_cfg.sv
module lse_cfg #(
    parameter int HEADER_BYTES = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr,
    input  logic [lse_pkg::PCOUNT_W-1:0]   cfg_data,
    output lse_pkg::lim_t                  lim
);
    import lse_pkg::*;

    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);

    logic [PCOUNT_W-1:0] pc_sat;
    logic [PCOUNT_W+1:0] pc_x3;
    logic [LEN_W-1:0]    cap_bytes;
    lim_t                lim_reg;
    lim_t                lim_next;

    // saturate, then floor(3 * pixels / 8) bytes of capacity
    always_comb begin
        pc_sat    = (cfg_data > PIXEL_LIMIT) ? PIXEL_LIMIT : cfg_data;
        pc_x3     = {2'b00, pc_sat} + {1'b0, pc_sat, 1'b0};
        cap_bytes = pc_x3[LEN_W+2:3];
        lim_next.fit_ok  = (cap_bytes >= HDR_LEN);
        lim_next.max_len = cap_bytes - HDR_LEN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= '0;
        end else if (cfg_wr) begin
            lim_reg <= lim_next;
        end
    end

    assign lim = lim_reg;

endmodule

### hw/rtl/lse_core.sv
module lse_core #(
    parameter int HEADER_BYTES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [lse_pkg::CHUNK_W-1:0]   chunk,
    input  logic                          frame_start,
    input  lse_pkg::lim_t                 lim,
    output logic                          res_valid,
    output lse_pkg::res_t                 res
);
    import lse_pkg::*;

    localparam logic [HDR_IDX_W:0] HDR_LAST = (HDR_IDX_W+1)'(HEADER_BYTES - 1);

    phase_t                 phase_reg, phase_next, phase_cur;
    logic [1:0]             chunk_idx_reg, chunk_idx_next, chunk_idx_cur;
    logic [7:0]             byte_asm_reg, byte_asm_next, byte_asm_cur;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next, hdr_idx_cur;
    logic [LEN_W-1:0]       len_lo_reg, len_lo_next, len_lo_cur;
    logic                   len_hi_reg, len_hi_next, len_hi_cur;
    logic [LEN_W-1:0]       remain_reg, remain_next, remain_cur;

    logic                   active;
    logic                   in_header;
    logic                   in_payload;
    logic [7:0]             placed;
    logic [7:0]             byte_full;
    logic                   byte_done;
    logic [63:0]            contrib;
    logic [LEN_W-1:0]       len_lo_full;
    logic                   len_hi_full;
    logic                   hdr_final;
    logic                   len_fit;
    logic                   pay_final;

    // frame start clears assembly state before this pixel is used
    always_comb begin
        phase_cur     = frame_start ? PH_HEADER : phase_reg;
        chunk_idx_cur = frame_start ? '0 : chunk_idx_reg;
        byte_asm_cur  = frame_start ? '0 : byte_asm_reg;
        hdr_idx_cur   = frame_start ? '0 : hdr_idx_reg;
        len_lo_cur    = frame_start ? '0 : len_lo_reg;
        len_hi_cur    = frame_start ? 1'b0 : len_hi_reg;
        remain_cur    = frame_start ? '0 : remain_reg;

        in_header  = (phase_cur == PH_HEADER);
        in_payload = (phase_cur == PH_PAYLOAD);
        active     = in_header || in_payload;

        case (chunk_idx_cur)
            2'd0:    placed = {5'b00000, chunk};
            2'd1:    placed = {2'b00, chunk, 3'b000};
            2'd2:    placed = {chunk[1:0], 6'b000000};
            default: placed = '0;
        endcase
        byte_full = byte_asm_cur | placed;
        byte_done = (chunk_idx_cur == 2'd2);

        contrib     = {56'd0, byte_full} << {hdr_idx_cur, 3'b000};
        len_lo_full = len_lo_cur | contrib[LEN_W-1:0];
        len_hi_full = len_hi_cur | (|contrib[63:LEN_W]);
        hdr_final   = ({1'b0, hdr_idx_cur} == HDR_LAST);
        len_fit     = lim.fit_ok && !len_hi_full && (len_lo_full != '0)
                      && (len_lo_full <= lim.max_len);
        pay_final   = (remain_cur <= LEN_W'(1));
    end

    always_comb begin
        phase_next = phase_reg;
        if (en) begin
            unique case (phase_cur)
                PH_HEADER: begin
                    phase_next = PH_HEADER;
                    if (byte_done && hdr_final) begin
                        phase_next = len_fit ? PH_PAYLOAD : PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    phase_next = PH_PAYLOAD;
                    if (byte_done && pay_final) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        chunk_idx_next = chunk_idx_reg;
        byte_asm_next  = byte_asm_reg;
        hdr_idx_next   = hdr_idx_reg;
        len_lo_next    = len_lo_reg;
        len_hi_next    = len_hi_reg;
        remain_next    = remain_reg;

        res_valid          = active && byte_done && ((in_header && hdr_final) || in_payload);
        res.kind           = in_payload ? KIND_PAYLOAD : (len_fit ? KIND_LEN_OK : KIND_LEN_BAD);
        res.payload_byte   = in_payload ? byte_full : 8'd0;
        res.length_value   = (in_header && len_fit) ? len_lo_full : '0;
        res.last           = in_payload && pay_final;

        if (en && active) begin
            hdr_idx_next = hdr_idx_cur;
            len_lo_next  = len_lo_cur;
            len_hi_next  = len_hi_cur;
            remain_next  = remain_cur;
            if (!byte_done) begin
                chunk_idx_next = chunk_idx_cur + 2'd1;
                byte_asm_next  = byte_full;
            end else begin
                chunk_idx_next = '0;
                byte_asm_next  = '0;
                if (in_header) begin
                    len_lo_next = len_lo_full;
                    len_hi_next = len_hi_full;
                    if (hdr_final) begin
                        hdr_idx_next = '0;
                        if (len_fit) begin
                            remain_next = len_lo_full;
                        end
                    end else begin
                        hdr_idx_next = hdr_idx_cur + HDR_IDX_W'(1);
                    end
                end else begin
                    remain_next = pay_final ? '0 : remain_cur - LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            chunk_idx_reg <= '0;
            byte_asm_reg  <= '0;
            hdr_idx_reg   <= '0;
            len_lo_reg    <= '0;
            len_hi_reg    <= 1'b0;
            remain_reg    <= '0;
        end else begin
            phase_reg     <= phase_next;
            chunk_idx_reg <= chunk_idx_next;
            byte_asm_reg  <= byte_asm_next;
            hdr_idx_reg   <= hdr_idx_next;
            len_lo_reg    <= len_lo_next;
            len_hi_reg    <= len_hi_next;
            remain_reg    <= remain_next;
        end
    end

endmodule

### hw/rtl/lsb_stego_extract_unit.sv
// 3-bit LSB steganography extractor.
// Input channel (s_*): one RGBA32 pixel per transaction; only bits 2..0 are used.
// s_frame_start marks the first pixel of an image and restarts extraction.
// Every three pixels build one byte. The first header bytes form a little-endian
// length, checked against the capacity given by the carrier's pixel total.
// Result channel (m_*): one transaction for the length verdict (accepted or
// rejected), then one per payload byte, m_last on the final byte. Pixels that
// complete no byte, and pixels outside a frame, give no transaction.
// Configuration channel (cfg_*): writes the carrier's pixel total; always ready; the
// user must see that it is used only between frames, which the block does not enforce.
// Each pixel passes the input register, the assembly logic and the result register.
// Throughput: one pixel per cycle while the receiver is ready, set by the single
// registered pass through the assembly logic between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers, returns to idle and
// sets the pixel total to zero, so every length is rejected until written.
// A stalled receiver holds the result; one more pixel waits in the input
// register, after which s_ready drops until m_ready returns.
module lsb_stego_extract_unit #(
    parameter int HEADER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pixel_word,
    input  logic        s_frame_start,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [22:0] m_length_value,
    output logic        m_last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_data
);
    import lse_pkg::*;

    logic               in_valid_reg;
    logic [CHUNK_W-1:0] in_chunk_reg;
    logic               in_fs_reg;
    logic               m_valid_reg;
    res_t               m_res_reg;

    logic               advance;
    logic               res_valid;
    res_t               res;
    lim_t               lim;

    assign cfg_ready = 1'b1;

    lse_cfg #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .lim      (lim)
    );

    lse_core #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .chunk       (in_chunk_reg),
        .frame_start (in_fs_reg),
        .lim         (lim),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_chunk_reg <= s_pixel_word[CHUNK_W-1:0];
            in_fs_reg    <= s_frame_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_res_reg.kind;
    assign m_payload_byte = m_res_reg.payload_byte;
    assign m_length_value = m_res_reg.length_value;
    assign m_last         = m_res_reg.last;

    a_last_only_on_payload : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_kind == KIND_PAYLOAD))
        else $error("last mark on a non-payload transaction");

    a_accepted_len_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_LEN_OK) |-> (m_length_value != '0))
        else $error("accepted length of zero");

    a_input_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_chunk_reg)
                                        && $stable(in_fs_reg)))
        else $error("pending pixel lost while result stalled");

    a_stall_blocks_core : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !advance)
        else $error("core advanced over a held result");

endmodule

### verif/lsb_stego_extract_unit_test.sv
`timescale 1ns / 1ps

module lsb_stego_extract_unit_test;

    import lse_pkg::*;

    localparam int HDR_BYTES   = 8;
    localparam int CYCLE_LIMIT = 250000;
    localparam int LONG_HOLD   = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_pixel_word = '0;
    logic        s_frame_start = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [22:0] m_length_value;
    logic        m_last;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [24:0] cfg_data = '0;

    lsb_stego_extract_unit #(
        .HEADER_BYTES(HDR_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_word  (s_pixel_word),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_payload_byte(m_payload_byte),
        .m_length_value(m_length_value),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Extraction state mirrored from the block
    phase_t            ext_phase;
    logic [1:0]        chunk_sel;
    logic [7:0]        byte_build;
    logic [2:0]        hdr_sel;
    logic [63:0]       len_build;
    logic [LEN_W-1:0]  bytes_left;
    logic [24:0]       carrier_px;

    res_t              predicted_results[$];
    int                error_count = 0;
    int                cycle_count = 0;

    logic              no_idle = 1'b0;
    int                hold_requests = 0;
    int                send_calm_left = 0;

    function automatic longint room_bytes(input logic [24:0] pcount);
        longint sat;
        sat = (pcount > PIXEL_LIMIT) ? longint'(PIXEL_LIMIT) : longint'(pcount);
        return ((sat * 3) >> 3) - HDR_BYTES;
    endfunction

    function automatic void clear_frame_state();
        chunk_sel  = '0;
        byte_build = '0;
        hdr_sel    = '0;
        len_build  = '0;
        bytes_left = '0;
    endfunction

    function automatic void extract_step(input logic [31:0] px, input logic fs);
        res_t       res;
        logic [7:0] done_byte;
        longint     room;
        if (fs) begin
            clear_frame_state();
            ext_phase = PH_HEADER;
        end
        if (ext_phase != PH_HEADER && ext_phase != PH_PAYLOAD)
            return;
        byte_build = byte_build | (8'(px[2:0]) << (chunk_sel * 3));
        chunk_sel++;
        if (chunk_sel < 3)
            return;
        chunk_sel  = '0;
        done_byte  = byte_build;
        byte_build = '0;
        res.payload_byte = '0;
        res.length_value = '0;
        res.last         = 1'b0;
        if (ext_phase == PH_HEADER) begin
            len_build = len_build | (64'(done_byte) << (hdr_sel * 8));
            if (hdr_sel < HDR_BYTES - 1) begin
                hdr_sel++;
                return;
            end
            hdr_sel = '0;
            room = room_bytes(carrier_px);
            if (len_build != 0 && room >= 0 && len_build <= $unsigned(room)) begin
                bytes_left       = len_build[LEN_W-1:0];
                ext_phase        = PH_PAYLOAD;
                res.kind         = KIND_LEN_OK;
                res.length_value = bytes_left;
            end else begin
                ext_phase = PH_IDLE;
                res.kind  = KIND_LEN_BAD;
            end
        end else begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = done_byte;
            res.last         = (bytes_left <= 1);
            if (bytes_left <= 1) begin
                bytes_left = '0;
                ext_phase  = PH_IDLE;
            end else begin
                bytes_left--;
            end
        end
        predicted_results.push_back(res);
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            carrier_px = '0;
            ext_phase  = PH_IDLE;
            clear_frame_state();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: kind %0d byte %0h length %0d last %0b",
                           m_kind, m_payload_byte, m_length_value, m_last);
                    error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_kind);
                        error_count++;
                    end
                    if (m_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want.payload_byte, m_payload_byte);
                        error_count++;
                    end
                    if (m_length_value !== want.length_value) begin
                        $error("length_value: expected %0d, actual %0d",
                               want.length_value, m_length_value);
                        error_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                extract_step(s_pixel_word, s_frame_start);
            if (cfg_valid && cfg_ready)
                carrier_px = cfg_data;
        end
    end

    // Receiver: short random stalls, calm stretches and requested long holds
    always @(posedge aclk) begin
        int hold_served;
        int hold_left;
        int stall_left;
        int calm_left;
        int roll;
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        roll = $urandom_range(0, 99);
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (no_idle || calm_left > 0) begin
            m_ready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
        end else if (roll < 15) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
        end else begin
            m_ready <= 1'b1;
            if (roll < 18)
                calm_left = $urandom_range(30, 80);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_pixel(input logic [31:0] px, input logic fs);
        int roll;
        roll = $urandom_range(0, 99);
        if (!no_idle && send_calm_left == 0 && roll < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end else if (send_calm_left > 0) begin
            send_calm_left--;
        end else if (roll < 23) begin
            send_calm_left = $urandom_range(30, 80);
        end
        s_valid       <= 1'b1;
        s_pixel_word  <= px;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Spread one byte over three pixels; the third chunk's top bit is random and ignored
    task automatic send_byte(input logic [7:0] b, input logic fs);
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        send_pixel({r0[31:3], b[2:0]}, fs);
        send_pixel({r1[31:3], b[5:3]}, 1'b0);
        send_pixel({r2[31:2], b[7:6]}, 1'b0);
    endtask

    task automatic send_frame(input logic [63:0] len, input int n_bytes);
        for (int i = 0; i < HDR_BYTES; i++)
            send_byte(len[8*i +: 8], i == 0);
        repeat (n_bytes) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_pixel($urandom, 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_carrier_px(input logic [24:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_after_reset();
        send_noise(5);
        send_frame(64'd5, 0);
        send_noise(4);
    endtask

    task automatic test_capacity_edges();
        write_carrier_px(25'd40);
        send_frame(64'd7, 7);
        send_noise(4);
        send_frame(64'd8, 0);
        send_frame(64'd0, 0);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_noise(3);
        write_carrier_px(25'd21);
        send_frame(64'd1, 0);
        write_carrier_px(25'd24);
        send_frame(64'd1, 1);
    endtask

    task automatic test_saturated_count();
        write_carrier_px('1);
        send_frame(64'd6291448, 2);
        send_frame(64'd6291449, 0);
        write_carrier_px(PIXEL_LIMIT);
        send_frame(64'd6291448, 1);
        send_frame(64'h0000_0100_0000_0003, 0);
        send_frame(64'h8000_0000_0000_0000, 0);
    endtask

    task automatic test_frame_restart();
        write_carrier_px(25'd200);
        send_byte(8'd9, 1'b1);
        send_byte(8'd0, 1'b0);
        send_frame(64'd4, 2);
        send_pixel($urandom, 1'b0);
        send_frame(64'd3, 3);
        send_pixel($urandom, 1'b1);
        send_frame(64'd2, 2);
    endtask

    task automatic test_output_backpressure();
        write_carrier_px(25'd2000);
        hold_requests <= hold_requests + 1;
        send_frame(64'd30, 30);
    endtask

    task automatic test_random_frames(input int target_pixels);
        int          sent;
        int          frame_no;
        int          pick;
        int          n;
        longint      room;
        logic [63:0] len;
        logic [24:0] pcount;
        sent = 0;
        frame_no = 0;
        while (sent < target_pixels) begin
            if (frame_no % 12 == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    pcount = 25'($urandom_range(24, 400));
                else if (pick < 8)
                    pcount = 25'($urandom);
                else if (pick == 8)
                    pcount = '1;
                else
                    pcount = 25'($urandom_range(0, 23));
                write_carrier_px(pcount);
            end
            room = room_bytes(pcount);
            pick = $urandom_range(0, 19);
            if (room >= 1 && pick < 14) begin
                n = $urandom_range(1, (room > 12) ? 12 : int'(room));
                if (pick < 12) begin
                    send_frame(64'(n), n);
                    send_noise(pick % 3);
                    sent += HDR_BYTES * 3 + 3 * n;
                end else begin
                    n = $urandom_range(0, n - 1);
                    send_frame(64'(n + 1), n);
                    send_noise(pick % 3);
                    sent += HDR_BYTES * 3 + 3 * n + pick % 3;
                end
            end else if (pick < 18) begin
                case (pick % 4)
                    0: len = 64'd0;
                    1: len = (room >= 0) ? 64'(room + 1 + $urandom_range(0, 50))
                                         : 64'($urandom_range(1, 50));
                    2: len = {$urandom, $urandom};
                    default: len = {32'd0, $urandom};
                endcase
                send_frame(len, 0);
                send_noise($urandom_range(0, 3));
                sent += HDR_BYTES * 3;
            end else begin
                n = $urandom_range(1, HDR_BYTES * 3 - 1);
                send_pixel($urandom, 1'b1);
                send_noise(n - 1);
                sent += n;
            end
            frame_no++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_after_reset();
        test_capacity_edges();
        test_saturated_count();
        test_frame_restart();
        test_output_backpressure();
        test_random_frames(1050);
        wait_drained();
        no_idle <= 1'b1;
        test_random_frames(150);
        wait_drained();
        repeat (6) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
